FILE: src/centered_fir_correlator_core_defines.svh
// Assertion macros used by the checker file cfc_core_checker.sv.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CENTERED_FIR_CORRELATOR_CORE_DEFINES_SVH
`define CENTERED_FIR_CORRELATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define CFC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CFC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/cfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_W      = 16;
	localparam int TAPS_W      = 3;
	localparam int SEEN_W      = 3;
	localparam int OUT_W       = 43;
	localparam int PROD_W      = SAMPLE_BITS + 1 + COEF_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [TAPS_W-1:0]    TAP_RESET     = 3'd7;
	localparam logic [SEEN_W-1:0]    SEEN_MAX      = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = 3'd1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		sample_t sample;
		logic    end_of_stream;
	} cfc_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    final_output;
	} cfc_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfc_cfg_t;

	// Window geometry derived from tap_count.
	typedef struct packed {
		logic [TAPS_W-1:0] taps;
		logic [TAPS_W-1:0] w;
		logic [TAPS_W-1:0] lat;
	} geom_t;

	// One result request from the issue stage to the MAC.
	typedef struct packed {
		logic              vld;
		logic [SEEN_W-1:0] d;
		logic              fin;
	} issue_t;

endpackage

`default_nettype wire

FILE: src/cfc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cfc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cfc_regs #(
	parameter int MAX_TAPS = 7
) (
	input  wire                   clk,
	input  wire                   arst_n,
	cfc_stream_if.sink            cfg,
	output cfc_pkg::coef_t        coef [MAX_TAPS],
	output cfc_pkg::geom_t        geom
);
	import cfc_pkg::*;

	logic [TAPS_W-1:0] tap_q;
	coef_t             coef_q [MAX_TAPS];
	logic [TAPS_W-1:0] taps;
	logic              wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= TAP_RESET;
			for (int k = 0; k < MAX_TAPS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (wr) begin
			if (cfg.data.index == REG_TAP_COUNT) begin
				tap_q <= cfg.data.value[TAPS_W-1:0];
			end
			for (int k = 0; k < MAX_TAPS; k++) begin
				if (cfg.data.index == REG_COEF_BASE + CFG_IDX_W'(k)) begin
					coef_q[k] <= coef_t'(cfg.data.value[COEF_W-1:0]);
				end
			end
		end
	end

	always_comb begin
		taps = (tap_q > TAPS_W'(MAX_TAPS)) ? TAPS_W'(MAX_TAPS) : tap_q;
		geom.taps = taps;
		if (taps == '0) begin
			geom.w   = '0;
			geom.lat = '0;
		end else begin
			geom.w   = (taps - 1'b1) >> 1;
			geom.lat = taps - 1'b1 - ((taps - 1'b1) >> 1);
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

FILE: src/cfc_window.sv
`timescale 1ns / 1ps
`default_nettype none

module cfc_window #(
	parameter int MAX_TAPS = 7
) (
	input  wire                   clk,
	input  wire                   arst_n,
	cfc_stream_if.sink            stream,
	input  cfc_pkg::geom_t        geom,
	input  wire                   take,
	output cfc_pkg::issue_t       iss,
	output cfc_pkg::sample_t      win [MAX_TAPS]
);
	import cfc_pkg::*;

	localparam int HIST_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

	sample_t           hist_q [HIST_D];
	logic [SEEN_W-1:0] seen_q;
	sample_t           h_new  [MAX_TAPS];
	sample_t           win_s1 [MAX_TAPS];
	logic              vld_s1;
	logic              last_s1;
	logic [SEEN_W-1:0] d_s1;

	logic              acc;
	logic              last;
	logic              load;
	logic              done;
	logic [SEEN_W-1:0] d_start;

	always_comb begin
		h_new[0] = stream.data.sample;
		for (int i = 1; i < MAX_TAPS; i++) begin
			h_new[i] = hist_q[i-1];
		end
	end

	assign acc  = stream.valid && stream.ready;
	assign last = stream.data.end_of_stream;

	// Flush starts at the oldest pending output that lies inside the stream.
	assign d_start = (last && (seen_q < SEEN_W'(geom.lat))) ? seen_q : SEEN_W'(geom.lat);
	assign load    = acc && (last || (SEEN_W'(geom.lat) <= seen_q));
	assign done    = vld_s1 && take && (!last_s1 || d_s1 == '0);

	assign stream.ready = !vld_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			d_s1    <= '0;
			for (int i = 0; i < HIST_D; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (acc) begin
				if (last) begin
					seen_q <= '0;
					for (int i = 0; i < HIST_D; i++) begin
						hist_q[i] <= '0;
					end
				end else begin
					if (seen_q != SEEN_MAX) begin
						seen_q <= seen_q + 1'b1;
					end
					for (int i = 0; i < HIST_D; i++) begin
						hist_q[i] <= h_new[i];
					end
				end
			end
			priority if (load) begin
				vld_s1  <= 1'b1;
				last_s1 <= last;
				d_s1    <= d_start;
			end else if (done) begin
				vld_s1 <= 1'b0;
			end else if (vld_s1 && take) begin
				d_s1 <= d_s1 - 1'b1;
			end else begin
				vld_s1 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			win_s1 <= h_new;
		end
	end

	assign iss.vld = vld_s1;
	assign iss.d   = d_s1;
	assign iss.fin = last_s1 && (d_s1 == '0);
	assign win     = win_s1;

endmodule

`default_nettype wire

FILE: src/cfc_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module cfc_mac #(
	parameter int MAX_TAPS = 7
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cfc_pkg::issue_t       iss,
	input  cfc_pkg::sample_t      win  [MAX_TAPS],
	input  cfc_pkg::coef_t        coef [MAX_TAPS],
	input  cfc_pkg::geom_t        geom,
	output logic                  take,
	cfc_stream_if.source          result
);
	import cfc_pkg::*;

	localparam int POS_W  = SEEN_W + 2;
	localparam int WIDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	prod_t                   prod_c  [MAX_TAPS];
	prod_t                   prod_s2 [MAX_TAPS];
	logic                    vld_s2;
	logic                    fin_s2;
	logic signed [OUT_W-1:0] sum_c;
	cfc_out_t                out_q;
	logic                    out_vld_q;
	logic                    out_free;

	// Tap k weighs the sample d + w - k places behind the newest one.
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
		logic signed [POS_W-1:0] pos;
		logic                    use_k;
		sample_t                 sel;

		assign pos = $signed({2'b00, iss.d}) + $signed({2'b00, geom.w}) - POS_W'(k);
		assign use_k = (TAPS_W'(k) < geom.taps) && !pos[POS_W-1] &&
			(pos <= $signed(POS_W'(MAX_TAPS - 1)));
		assign sel = win[pos[WIDX_W-1:0]];
		// both arms signed so the weight is sign-extended
		assign prod_c[k] = use_k ? $signed({1'b0, sel}) * coef[k] : prod_t'(0);
	end

	assign out_free = !out_vld_q || result.ready;
	assign take     = !vld_s2 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s2 <= iss.vld;
			end
			if (out_free) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < MAX_TAPS; k++) begin
			sum_c = sum_c + OUT_W'(prod_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (take && iss.vld) begin
			prod_s2 <= prod_c;
			fin_s2  <= iss.fin;
		end
		if (out_free && vld_s2) begin
			out_q.filtered     <= sum_c;
			out_q.final_output <= fin_s2;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

endmodule

`default_nettype wire

FILE: src/centered_fir_correlator_core.sv
// Centered FIR correlator: streams unsigned samples through up to MAX_TAPS signed Q1.15
// taps and returns exact sums with 15 fraction bits. One sample is taken per clock while
// the issue register is free or releasing and results are not stalled; a sample marked
// end_of_stream holds the issue register until each flushed result, up to four
// (tap_count/2 + 1), is taken, while the tail is emitted with zero padding. Results pass
// through the issue, product and sum registers. Configuration (index 0 tap_count, 1..
// coefficients) may be written only while the block is idle; it applies to the next sample.
`timescale 1ns / 1ps
`default_nettype none

module centered_fir_correlator_core #(
	parameter int MAX_TAPS = 7
) (
	input  wire          clk,
	input  wire          arst_n,
	cfc_stream_if.sink   stream,
	cfc_stream_if.source result,
	cfc_stream_if.sink   cfg
);
	import cfc_pkg::*;

	coef_t   coef [MAX_TAPS];
	geom_t   geom;
	issue_t  iss;
	sample_t win  [MAX_TAPS];
	logic    take;

	cfc_regs #(.MAX_TAPS(MAX_TAPS)) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef),
		.geom   (geom)
	);

	cfc_window #(.MAX_TAPS(MAX_TAPS)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.geom   (geom),
		.take   (take),
		.iss    (iss),
		.win    (win)
	);

	cfc_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.iss    (iss),
		.win    (win),
		.coef   (coef),
		.geom   (geom),
		.take   (take),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: src/cfc_core_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "centered_fir_correlator_core_defines.svh"

module cfc_core_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        in_last,
	input wire        out_valid,
	input wire        out_ready,
	input wire [42:0] out_filtered,
	input wire        out_final
);
	logic [2:0] pend_q;
	logic       any_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count of end-of-stream requests whose final result is still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			any_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				any_q <= 1'b1;
			end
			pend_q <= pend_q + 3'(in_acc && in_last) - 3'(out_acc && out_final);
		end
	end

	`CFC_ASSERT_NXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "result dropped")
	`CFC_ASSERT_NXT(a_out_data_hold, out_valid && !out_ready,
		$stable(out_filtered) && $stable(out_final), "stalled result changed")
	`CFC_ASSERT_IMP(a_final_owed, out_valid && out_final, pend_q != 3'd0, "unowed final")
	`CFC_ASSERT_IMP(a_result_after_input, out_valid, any_q, "result before any request")

endmodule

bind centered_fir_correlator_core cfc_core_checker u_cfc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (stream.valid),
	.in_ready     (stream.ready),
	.in_last      (stream.data.end_of_stream),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_filtered (result.data.filtered),
	.out_final    (result.data.final_output)
);

`default_nettype wire
